FILE: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define FCC_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// Check that a consequent follows an antecedent in the same cycle.
`define FCC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent follows an antecedent in the next cycle.
`define FCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/fcc_pkg.sv
// Types and constants of the flow change cache.
package fcc_pkg;

  // Default sizes
  localparam int unsigned TABLE_ENTRIES_DEF = 128;
  localparam int unsigned AMOUNT_BITS_DEF   = 64;

  // Key layout inside one table row: direction, key high, key low, then amount
  localparam int unsigned NODE_BITS = 64;
  localparam int unsigned DIR_LSB   = 0;
  localparam int unsigned HI_LSB    = 1;
  localparam int unsigned LO_LSB    = HI_LSB + NODE_BITS;
  localparam int unsigned KEY_BITS  = LO_LSB + NODE_BITS;

  // Stream layout
  localparam int unsigned IN_TDATA_W  = 3 * NODE_BITS;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned TUSER_CMD   = 0;
  localparam int unsigned TUSER_DIR   = 1;
  localparam int unsigned TDATA_HI    = 0;
  localparam int unsigned TDATA_LO    = NODE_BITS;
  localparam int unsigned TDATA_FLOW  = 2 * NODE_BITS;

  typedef enum logic {
    CMD_CHECK   = 1'b0,
    CMD_PRELOAD = 1'b1
  } fcc_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_RESP
  } fcc_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } fcc_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic rd_last;
  } fcc_stat_t;

endpackage

FILE: rtl/core/fcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/fcc_ctrl.sv
// Controller state machine of the flow change cache.
module fcc_ctrl import fcc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output fcc_ctrl_t ctrl_o,
  input  fcc_stat_t stat_i
);

  fcc_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.rd_last) state_d = ST_DRAIN;
      end
      ST_DRAIN:  state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_RESP;
      ST_RESP: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctrl_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      ST_SCAN:   ctrl_o.scan   = 1'b1;
      ST_DRAIN:  ctrl_o        = '0;
      ST_COMMIT: ctrl_o.commit = 1'b1;
      ST_RESP:   out_valid_o   = 1'b1;
      default:   ctrl_o        = '0;
    endcase
  end

endmodule

FILE: rtl/core/fcc_dp.sv
// Datapath of the flow change cache: key registers, table scan, update.
module fcc_dp import fcc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned AMOUNT_BITS   = AMOUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fcc_ctrl_t             ctrl_i,
  output fcc_stat_t             stat_o,
  input  logic                  cmd_i,
  input  logic                  dir_i,
  input  logic [NODE_BITS-1:0]  hi_i,
  input  logic [NODE_BITS-1:0]  lo_i,
  input  logic [AMOUNT_BITS-1:0] flow_i,
  output logic                  cached_o,
  output logic                  full_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int unsigned WORD_W = KEY_BITS + AMOUNT_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Item registers
  fcc_cmd_e              cmd_q;
  logic                  dir_q;
  logic [NODE_BITS-1:0]  hi_q, lo_q;
  logic [AMOUNT_BITS-1:0] flow_q;

  // Scan and result state
  logic [IDX_W-1:0]       rd_idx_q, cmp_idx_q, match_idx_q, free_idx_q;
  logic                   cmp_vld_q, match_found_q, free_found_q;
  logic [AMOUNT_BITS-1:0] match_flow_q;
  logic                   cached_q, full_q;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;

  logic [WORD_W-1:0] rdata, wdata;
  logic              row_hit, row_free;
  logic              ins, upd, ers, cached_d, full_d, we;
  logic [IDX_W-1:0]  waddr;
  logic              flow_zero, flow_same;

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= fcc_cmd_e'(cmd_i);
      dir_q  <= dir_i;
      hi_q   <= hi_i;
      lo_q   <= lo_i;
      flow_q <= flow_i;
    end
  end

  // Table rows
  fcc_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (ctrl_i.scan),
    .raddr_i(rd_idx_q),
    .rdata_o(rdata)
  );

  // Compare the row read in the previous cycle
  assign row_hit = cmp_vld_q && valid_q[cmp_idx_q]
                && (rdata[DIR_LSB] == dir_q)
                && (rdata[HI_LSB +: NODE_BITS] == hi_q)
                && (rdata[LO_LSB +: NODE_BITS] == lo_q);
  assign row_free = cmp_vld_q && !valid_q[cmp_idx_q];

  assign stat_o.rd_last = (rd_idx_q == LAST_IDX);

  // Advance the scan, keep the match and the lowest free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q      <= '0;
      cmp_vld_q     <= 1'b0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
    end else begin
      cmp_vld_q <= ctrl_i.scan;
      if (ctrl_i.load) begin
        rd_idx_q      <= '0;
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
      end else begin
        if (ctrl_i.scan) rd_idx_q <= rd_idx_q + 1'b1;
        if (row_hit) match_found_q <= 1'b1;
        if (row_free) free_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= rd_idx_q;
    if (row_hit) begin
      match_idx_q  <= cmp_idx_q;
      match_flow_q <= rdata[KEY_BITS +: AMOUNT_BITS];
    end
    if (row_free && !free_found_q) begin
      free_idx_q <= cmp_idx_q;
    end
  end

  // Decide the update
  assign flow_zero = (flow_q == '0);
  assign flow_same = (match_flow_q == flow_q);

  always_comb begin
    ins      = 1'b0;
    upd      = 1'b0;
    ers      = 1'b0;
    cached_d = 1'b0;
    full_d   = 1'b0;
    if (cmd_q == CMD_PRELOAD) begin
      if (match_found_q)     cached_d = 1'b1;
      else if (free_found_q) ins      = 1'b1;
      else                   full_d   = 1'b1;
    end else if (!match_found_q) begin
      if (flow_zero)         cached_d = 1'b1;
      else if (free_found_q) ins      = 1'b1;
      else                   full_d   = 1'b1;
    end else if (flow_zero) begin
      ers = 1'b1;
    end else if (!flow_same) begin
      upd = 1'b1;
    end else begin
      cached_d = 1'b1;
    end
  end

  assign we    = ctrl_i.commit && (ins || upd);
  assign waddr = ins ? free_idx_q : match_idx_q;
  assign wdata = {flow_q, lo_q, hi_q, dir_q};

  // Set or drop the valid bit of the touched slot
  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.commit && ins) valid_d[free_idx_q]  = 1'b1;
    if (ctrl_i.commit && ers) valid_d[match_idx_q] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the result for the output beat
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      cached_q <= cached_d;
      full_q   <= full_d;
    end
  end

  assign cached_o = cached_q;
  assign full_o   = full_q;

endmodule

FILE: rtl/core/flow_change_cache_core.sv
// Top level of the flow change cache: controller, datapath and stream ports.
// Each accepted item passes the states scan, drain, commit and resp in that order.
// The scan reads the full table memory, one row per cycle on its read port.
// Reset clears all valid bits at once; the table rows keep whatever they held.
// No new item is taken until the result beat of the previous one is accepted.
module flow_change_cache_core import fcc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned AMOUNT_BITS   = AMOUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // node_id_high [63:0], node_id_low [127:64], flow_amount [191:128]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command [0], direction [1]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // already_cached [0], table_full [1], zero [7:2]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  fcc_ctrl_t ctrl;
  fcc_stat_t stat;
  logic      cached, full;

  fcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .ctrl_o     (ctrl),
    .stat_i     (stat)
  );

  fcc_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .AMOUNT_BITS  (AMOUNT_BITS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .cmd_i   (s_axis_tuser[TUSER_CMD]),
    .dir_i   (s_axis_tuser[TUSER_DIR]),
    .hi_i    (s_axis_tdata[TDATA_HI +: NODE_BITS]),
    .lo_i    (s_axis_tdata[TDATA_LO +: NODE_BITS]),
    .flow_i  (s_axis_tdata[TDATA_FLOW +: AMOUNT_BITS]),
    .cached_o(cached),
    .full_o  (full)
  );

  // Pack the result beat
  assign m_axis_tdata = {(OUT_TDATA_W - 2)'(0), full, cached};

endmodule

FILE: rtl/core/fcc_checker.sv
// Port-level assertions for the flow change cache, bound to the top level.
`include "assert_macros.svh"

module fcc_checker import fcc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // One item at a time: no input beat right after one was taken
  `FCC_ASSERT_NEXT(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken twice in a row")

  // No input beat while a result waits
  `FCC_ASSERT_SAME(a_no_overlap, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready, "input ready while result pending")

  // Cached and full never both
  `FCC_ASSERT_SAME(a_flags, clk_i, rst_ni, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]), "cached and full both set")

  // A stalled result holds
  `FCC_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind flow_change_cache_core fcc_checker u_fcc_checker (.*);
